// ===== hw/rtl/dpl_pkg.sv =====
// Package for the date period length block: request/response payload types,
// calendar constants and the month length table. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dpl_pkg;

   // Request payload: start date, end date and include-end flag
   typedef struct packed {
      logic [4:0]  start_day;
      logic [3:0]  start_month;
      logic [13:0] start_year;
      logic [4:0]  end_day;
      logic [3:0]  end_month;
      logic [13:0] end_year;
      logic        include_end;
   } dpl_req_type;

   // Response payload
   typedef struct packed {
      logic [21:0] length_days;
      logic        status;
   } dpl_rsp_type;

   // Status codes
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // Calendar constants
   localparam logic [3:0]  MONTH_JAN    = 4'd1;
   localparam logic [3:0]  MONTH_FEB    = 4'd2;
   localparam logic [3:0]  MONTH_DEC    = 4'd12;
   localparam logic [4:0]  DAY_FIRST    = 5'd1;
   localparam logic [4:0]  FEB_LEAP_LEN = 5'd29;
   localparam logic [16:0] DPL_MAX_YEAR = 17'd9999;

   // Count width and saturation value
   localparam int unsigned  LEN_W   = 22;
   localparam logic [21:0]  LEN_MAX = 22'h3FFFFF;

   // Reciprocal of 100 for 14-bit years: q = (y * 5243) >> 19
   localparam logic [12:0] RECIP_100 = 13'd5243;
   localparam int unsigned RECIP_SH  = 19;

   // Length of a month in a common year; codes outside 1..12 read as 31
   function automatic logic [4:0] month_len(input logic [3:0] m);
      logic [4:0] len;
      case (m)
         4'd2:    len = 5'd28;
         4'd4:    len = 5'd30;
         4'd6:    len = 5'd30;
         4'd9:    len = 5'd30;
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

// ===== hw/rtl/dpl_cal_unit.sv =====
// Shared calendar unit: days in a given month of a given year (Gregorian).
// Depends on dpl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpl_cal_unit
   import dpl_pkg::*;
(
   input  wire logic [3:0]  month,
   input  wire logic [13:0] year,
   output logic      [4:0]  month_days
);

   logic [26:0] prod;
   logic [7:0]  q100;
   logic [14:0] back100;
   logic        div100;
   logic        leap;

   // Century test through the reciprocal, then multiply back by 100 with shifts
   assign prod    = 27'(year) * 27'(RECIP_100);
   assign q100    = prod[26:RECIP_SH];
   assign back100 = {1'b0, q100, 6'b0} + {2'b0, q100, 5'b0} + {5'b0, q100, 2'b0};
   assign div100  = (back100 == {1'b0, year});

   // Leap: by 400, or by 4 and not by 100
   assign leap = div100 ? (q100[1:0] == 2'b00) : (year[1:0] == 2'b00);

   assign month_days = (month == MONTH_FEB && leap) ? FEB_LEAP_LEN : month_len(month);

endmodule

`default_nettype wire

// ===== hw/rtl/date_period_length.sv =====
// Date period length: counts the days between two Gregorian dates.
// Depends on dpl_pkg and dpl_cal_unit.
//
// Usage
//   A request on req_* (valid/ready) carries a start date, an end date and
//   an include-end flag. One response on rsp_* (valid/ready) follows per
//   request: the day count (plus one when include_end is set) and status 0,
//   or length 0 and status 1 when either date is invalid (month outside
//   1..12, day 0 or past the month's end, year above 9999) or the end lies
//   before the start. Counts beyond 22 bits saturate.
//   Timing: the working date is stepped forward one day per cycle by a
//   single calendar unit after the start and end date checks; rsp_valid
//   rises once it reaches the end date. The number of days between the
//   dates is at most 3652424. On error no stepping is done and the
//   response follows the checks. The next request can be taken in the
//   same cycle as rsp_valid rises, as the block returns to idle then.
//   req_ready is high only while idle; one request is worked on at a time.
//   The response sits in an output register: a new request can be taken
//   while it waits, and a finished count holds in place until the register
//   is free. Reset (synchronous) returns to idle and drops rsp_valid.
`timescale 1ns / 1ps
`default_nettype none

module date_period_length
   import dpl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire dpl_req_type req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output dpl_rsp_type      rsp_payload
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHK_START,
      S_CHK_END,
      S_STEP,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   dpl_req_type       req_ff, req_in;
   logic [4:0]        wday_ff, wday_in;
   logic [3:0]        wmon_ff, wmon_in;
   logic [13:0]       wyear_ff, wyear_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic              err_ff, err_in;
   logic              rsp_valid_ff, rsp_valid_in;
   dpl_rsp_type       rsp_ff, rsp_in;

   logic [4:0]        u_day;
   logic [3:0]        u_mon;
   logic [13:0]       u_year;
   logic [4:0]        u_mdays;
   logic              date_ok;
   logic              end_early;
   logic              at_end;
   logic [LEN_W:0]    len_sum;
   logic [LEN_W-1:0]  len_final;

   // Calendar unit input: end date while checking it, else the working date
   always_comb begin
      if (state_ff == S_CHK_END) begin
         u_day  = req_ff.end_day;
         u_mon  = req_ff.end_month;
         u_year = req_ff.end_year;
      end else begin
         u_day  = wday_ff;
         u_mon  = wmon_ff;
         u_year = wyear_ff;
      end
   end

   dpl_cal_unit u_cal (
      .month      (u_mon),
      .year       (u_year),
      .month_days (u_mdays)
   );

   // Date checks
   assign date_ok = (u_mon inside {[MONTH_JAN:MONTH_DEC]}) &&
                    ({3'b000, u_year} <= DPL_MAX_YEAR) &&
                    (u_day != 5'd0) && (u_day <= u_mdays);
   assign end_early = {req_ff.end_year, req_ff.end_month, req_ff.end_day} <
                      {wyear_ff, wmon_ff, wday_ff};
   assign at_end    = (wyear_ff == req_ff.end_year) && (wmon_ff == req_ff.end_month) &&
                      (wday_ff == req_ff.end_day);

   // Final count with the end day, saturating
   assign len_sum   = {1'b0, cnt_ff} + {{LEN_W{1'b0}}, req_ff.include_end};
   assign len_final = len_sum[LEN_W] ? LEN_MAX : len_sum[LEN_W-1:0];

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      wday_in      = wday_ff;
      wmon_in      = wmon_ff;
      wyear_in     = wyear_ff;
      cnt_in       = cnt_ff;
      err_in       = err_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               wday_in  = req_payload.start_day;
               wmon_in  = req_payload.start_month;
               wyear_in = req_payload.start_year;
               cnt_in   = '0;
               err_in   = 1'b0;
               state_in = S_CHK_START;
            end
         end
         S_CHK_START: begin
            err_in   = ~date_ok;
            state_in = S_CHK_END;
         end
         S_CHK_END: begin
            err_in   = err_ff | ~date_ok | end_early;
            state_in = (err_ff | ~date_ok | end_early) ? S_DONE : S_STEP;
         end
         S_STEP: begin
            if (at_end) begin
               state_in = S_DONE;
            end else begin
               // advance the working date by one day
               if (wday_ff == u_mdays) begin
                  wday_in = DAY_FIRST;
                  if (wmon_ff == MONTH_DEC) begin
                     wmon_in  = MONTH_JAN;
                     wyear_in = wyear_ff + 14'd1;
                  end else begin
                     wmon_in = wmon_ff + 4'd1;
                  end
               end else begin
                  wday_in = wday_ff + 5'd1;
               end
               if (cnt_ff != LEN_MAX) begin
                  cnt_in = cnt_ff + {{(LEN_W-1){1'b0}}, 1'b1};
               end
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               if (err_ff) begin
                  rsp_in.length_days = '0;
                  rsp_in.status      = STATUS_ERR;
               end else begin
                  rsp_in.length_days = len_final;
                  rsp_in.status      = STATUS_OK;
               end
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff   <= req_in;
      wday_ff  <= wday_in;
      wmon_ff  <= wmon_in;
      wyear_ff <= wyear_in;
      cnt_ff   <= cnt_in;
      err_ff   <= err_in;
      rsp_ff   <= rsp_in;
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/dpl_checker.sv =====
// Port-level checks for date_period_length, attached by the bind below.
// Depends on dpl_pkg and date_period_length.
`timescale 1ns / 1ps
`default_nettype none

module dpl_checker
   import dpl_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire dpl_req_type req_payload,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire dpl_rsp_type rsp_payload
);

   // No response straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // Busy once a request has been taken
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready straight after accepting a request");

   // Error responses carry no count
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == STATUS_ERR |-> rsp_payload.length_days == '0)
      else $error("error response with non-zero length");

   // A waiting request holds until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_payload))
      else $error("waiting request changed");

endmodule

bind date_period_length dpl_checker u_dpl_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
